>>> rtl/damped_cosine_sum_evaluator_top_assert.svh
// ---------------------------------------------------------------------------
// Damped cosine sum evaluator - assertion macros
// Concurrent checks clocked on clk, switched off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DAMPED_COSINE_SUM_EVALUATOR_TOP_ASSERT_SVH
`define DAMPED_COSINE_SUM_EVALUATOR_TOP_ASSERT_SVH

// same-cycle implication
`define DCSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dcse_pkg.sv
// ---------------------------------------------------------------------------
// dcse_pkg
// Shared types, constants and tables of the damped cosine sum evaluator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcse_pkg;

  localparam int unsigned SIG_IDX_W  = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned ACC_W      = 56;
  localparam int unsigned OUT_W      = 48;

  localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNALS    = 1'd1;

  localparam logic [1:0] REQ_EVAL     = 2'd0;
  localparam logic [1:0] REQ_LOAD_AMP = 2'd1;
  localparam logic [1:0] REQ_LOAD_SIG = 2'd2;

  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [63:0] HALF_Q30    = 64'h0000_0000_2000_0000;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] INV_E_Q30   = 32'd395007542;
  localparam logic [31:0] EXP_LIMIT   = 32'd22;
  localparam logic [3:0]  EXP_STEPS   = 4'd12;
  localparam logic [3:0]  COS_STEPS   = 4'd6;

  // quarter-turn offsets, one-dimensional and two-dimensional models
  localparam logic [1:0] MOD_ONE [4] = '{2'd0, 2'd1, 2'd3, 2'd0};
  localparam logic [1:0] MOD_TWO [32] = '{
    2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
    2'd3, 2'd0, 2'd0, 2'd0, 2'd3, 2'd1, 2'd0, 2'd1,
    2'd0, 2'd3, 2'd1, 2'd3, 2'd0, 2'd0, 2'd1, 2'd0,
    2'd3, 2'd3, 2'd0, 2'd3, 2'd3, 2'd0, 2'd0, 2'd0
  };

  typedef enum logic [3:0] {
    MS_NONE, MS_ZT, MS_PH, MS_FT, MS_XT, MS_DIV, MS_QC,
    MS_INVE, MS_RE, MS_X, MS_XX, MS_MC, MS_AM
  } mul_sel_t;

  typedef enum logic [3:0] {
    WB_NONE, WB_Z, WB_PH, WB_P, WB_Q0, WB_T, WB_E,
    WB_R, WB_X, WB_X2, WB_MAG, WB_ACC
  } wb_sel_t;

  typedef struct packed {
    logic                 take;
    logic                 rd_sig;
    logic                 rd_amp;
    logic                 acc_clr;
    logic                 r_init;
    logic                 mag_init;
    logic                 cos_prep;
    logic                 t_zero;
    logic                 out_wr;
    logic                 out_bad;
    mul_sel_t             mul_sel;
    wb_sel_t              wb_sel;
    logic [SIG_IDX_W-1:0] sig;
    logic [1:0]           term;
    logic                 dim;
    logic [1:0]           off;
    logic [7:0]           div_c;
    logic [31:0]          div_m;
  } dcse_cmd_t;

  typedef struct packed {
    logic [4:0] exp_n;
    logic       exp_big;
    logic       out_free;
  } dcse_sts_t;

  // series divisor of a Horner step: i for exp, (2i-1)(2i) for cos
  function automatic logic [7:0] div_const(logic cos_mode, logic [3:0] step);
    logic [7:0] c;
    c = {4'd0, step};
    if (cos_mode) begin
      unique case (step)
        4'd1:    c = 8'd2;
        4'd2:    c = 8'd12;
        4'd3:    c = 8'd30;
        4'd4:    c = 8'd56;
        4'd5:    c = 8'd90;
        4'd6:    c = 8'd132;
        default: c = 8'd1;
      endcase
    end
    return c;
  endfunction

  // floor(2^32 / divisor), the top case held one below 2^32
  function automatic logic [31:0] div_recip(logic cos_mode, logic [3:0] step);
    logic [31:0] m;
    m = 32'd4294967295;
    if (cos_mode) begin
      unique case (step)
        4'd1:    m = 32'd2147483648;
        4'd2:    m = 32'd357913941;
        4'd3:    m = 32'd143165576;
        4'd4:    m = 32'd76695844;
        4'd5:    m = 32'd47721858;
        4'd6:    m = 32'd32537631;
        default: m = 32'd4294967295;
      endcase
    end else begin
      unique case (step)
        4'd2:    m = 32'd2147483648;
        4'd3:    m = 32'd1431655765;
        4'd4:    m = 32'd1073741824;
        4'd5:    m = 32'd858993459;
        4'd6:    m = 32'd715827882;
        4'd7:    m = 32'd613566756;
        4'd8:    m = 32'd536870912;
        4'd9:    m = 32'd477218588;
        4'd10:   m = 32'd429496729;
        4'd11:   m = 32'd390451572;
        4'd12:   m = 32'd357913941;
        default: m = 32'd4294967295;
      endcase
    end
    return m;
  endfunction

endpackage

>>> rtl/damped_cosine_sum_evaluator_top.sv
// ---------------------------------------------------------------------------
// damped_cosine_sum_evaluator_top
// Sum of exponentially damped sinusoids over signals and phase terms.
// Input channel in_*: valid/stall; a request is taken when in_valid is high
// and in_stall low. Load requests fill the amplitude, frequency and rate
// tables and give no result. An evaluate request gives one result on
// out_*, held until out_stall is low. Evaluation runs on one shared 32x32
// multiplier with a registered product. A dimension whose whole part
// of rate*time is 22 or more skips the exp series; its damping factor
// is zero.
// One request is in work at a time; a finished result waits in the output
// register, and the next request is taken while it waits.
// Reset (rst_n low, synchronous) clears tables, dimensions = 1, signals = 1.
// Configuration writes via cfg_we/cfg_index/cfg_wdata only while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module damped_cosine_sum_evaluator_top #(
  parameter int MAX_SIGNALS = 16,
  parameter int MAX_DIMS    = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dcse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcse_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_req_type,
  input  logic [1:0]                      in_phase_index,
  input  logic [1:0]                      in_term_index,
  input  logic [3:0]                      in_signal_index,
  input  logic                            in_dim_index,
  input  logic [31:0]                     in_time_first,
  input  logic [31:0]                     in_time_second,
  input  logic signed [31:0]              in_amplitude_value,
  input  logic signed [31:0]              in_frequency_value,
  input  logic [31:0]                     in_rate_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [47:0]              out_signal_value,
  output logic                            out_bad_phase
);
  import dcse_pkg::*;

  dcse_cmd_t cmd;
  dcse_sts_t sts;

  dcse_ctrl #(
    .MAX_SIGNALS (MAX_SIGNALS),
    .MAX_DIMS    (MAX_DIMS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_phase_index (in_phase_index),
    .cmd            (cmd),
    .sts            (sts)
  );

  dcse_dp #(
    .MAX_SIGNALS (MAX_SIGNALS),
    .MAX_DIMS    (MAX_DIMS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_req_type        (in_req_type),
    .in_term_index      (in_term_index),
    .in_signal_index    (in_signal_index),
    .in_dim_index       (in_dim_index),
    .in_time_first      (in_time_first),
    .in_time_second     (in_time_second),
    .in_amplitude_value (in_amplitude_value),
    .in_frequency_value (in_frequency_value),
    .in_rate_value      (in_rate_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_signal_value   (out_signal_value),
    .out_bad_phase      (out_bad_phase),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

>>> rtl/dcse_dp.sv
// ---------------------------------------------------------------------------
// dcse_dp
// Datapath: parameter tables, one shared 32x32 multiplier with its product
// register, Horner/divide working registers, accumulator, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcse_dp #(
  parameter int MAX_SIGNALS = 16,
  parameter int MAX_DIMS    = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_req_type,
  input  logic [1:0]          in_term_index,
  input  logic [3:0]          in_signal_index,
  input  logic                in_dim_index,
  input  logic [31:0]         in_time_first,
  input  logic [31:0]         in_time_second,
  input  logic signed [31:0]  in_amplitude_value,
  input  logic signed [31:0]  in_frequency_value,
  input  logic [31:0]         in_rate_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  out_signal_value,
  output logic                out_bad_phase,
  input  dcse_pkg::dcse_cmd_t cmd,
  output dcse_pkg::dcse_sts_t sts
);
  import dcse_pkg::*;

  localparam int AMP_DEPTH = 4 * MAX_SIGNALS;
  localparam int AMP_AW    = $clog2(AMP_DEPTH);
  localparam int SIG_DEPTH = MAX_SIGNALS * MAX_DIMS;
  localparam int SIG_AW    = (SIG_DEPTH > 1) ? $clog2(SIG_DEPTH) : 1;

  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic [31:0] amp_mem  [AMP_DEPTH];
  logic [31:0] freq_mem [SIG_DEPTH];
  logic [31:0] rate_mem [SIG_DEPTH];
  logic [AMP_DEPTH-1:0] amp_vld_r;
  logic [SIG_DEPTH-1:0] sig_vld_r;

  logic [31:0] amp_rd_r, freq_rd_r, rate_rd_r;
  logic        amp_rd_vld_r, sig_rd_vld_r;

  logic [31:0] time0_r, time1_r;
  logic [63:0] prod_r;
  logic [29:0] f_r;
  logic [4:0]  n_r;
  logic        big_r;
  logic [30:0] t_r, r_r, x_r, mag_r, rq_r;
  logic [31:0] x2_r, p_r, q0_r, am_r;
  logic        neg_r;
  logic [1:0][31:0] ph_r;
  logic signed [ACC_W-1:0] acc_r;

  logic              out_valid_r, out_bad_r;
  logic signed [47:0] out_value_r;

  logic              load_amp, load_sig;
  logic [AMP_AW-1:0] amp_waddr, amp_raddr;
  logic [SIG_AW-1:0] sig_waddr, sig_raddr;
  logic [31:0]       amp_eff, amp_mag, rate_eff, freq_eff, freq_mag, tsel;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       rnd_sum, ph_raw;
  logic [33:0]       rnd_w;
  logic [31:0]       rem;
  logic [32:0]       quot;
  logic [30:0]       t_step;
  logic [1:0]        quad;
  logic [29:0]       ph_frac;
  logic signed [ACC_W-1:0] term_s;

  assign load_amp  = cmd.take && (in_req_type == REQ_LOAD_AMP)
                     && (int'(in_signal_index) < MAX_SIGNALS);
  assign load_sig  = cmd.take && (in_req_type == REQ_LOAD_SIG)
                     && (int'(in_signal_index) < MAX_SIGNALS)
                     && (int'(in_dim_index) < MAX_DIMS);
  assign amp_waddr = AMP_AW'(int'(in_term_index) * MAX_SIGNALS + int'(in_signal_index));
  assign sig_waddr = SIG_AW'(int'(in_signal_index) * MAX_DIMS + int'(in_dim_index));
  assign amp_raddr = AMP_AW'(int'(cmd.term) * MAX_SIGNALS + int'(cmd.sig));
  assign sig_raddr = SIG_AW'(int'(cmd.sig) * MAX_DIMS + int'(cmd.dim));

  // never-written entries read as zero
  assign amp_eff  = amp_rd_vld_r ? amp_rd_r : 32'd0;
  assign rate_eff = sig_rd_vld_r ? rate_rd_r : 32'd0;
  assign freq_eff = sig_rd_vld_r ? freq_rd_r : 32'd0;
  assign amp_mag  = amp_eff[31] ? (32'd0 - amp_eff) : amp_eff;
  assign freq_mag = freq_eff[31] ? (32'd0 - freq_eff) : freq_eff;
  assign tsel     = cmd.dim ? time1_r : time0_r;

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (cmd.mul_sel)
      MS_ZT:   begin mul_a = rate_eff;       mul_b = tsel;              end
      MS_PH:   begin mul_a = freq_mag;       mul_b = tsel;              end
      MS_FT:   begin mul_a = {2'b0, f_r};    mul_b = {1'b0, t_r};       end
      MS_XT:   begin mul_a = x2_r;           mul_b = {1'b0, t_r};       end
      MS_DIV:  begin mul_a = p_r;            mul_b = cmd.div_m;         end
      // quotient estimate taken straight from the product register
      MS_QC:   begin mul_a = prod_r[63:32];  mul_b = {24'd0, cmd.div_c}; end
      MS_INVE: begin mul_a = {1'b0, t_r};    mul_b = INV_E_Q30;         end
      MS_RE:   begin mul_a = {1'b0, r_r};    mul_b = {1'b0, t_r};       end
      MS_X:    begin mul_a = {1'b0, rq_r};   mul_b = HALF_PI_Q30;       end
      MS_XX:   begin mul_a = {1'b0, x_r};    mul_b = {1'b0, x_r};       end
      MS_MC:   begin mul_a = {1'b0, mag_r};  mul_b = {1'b0, t_r};       end
      MS_AM:   begin mul_a = am_r;           mul_b = {1'b0, mag_r};     end
      default: begin mul_a = 32'd0;          mul_b = 32'd0;             end
    endcase
  end

  // Q30 rounding of the registered product
  assign rnd_sum = prod_r + HALF_Q30;
  assign rnd_w   = rnd_sum[63:30];
  assign ph_raw  = freq_eff[31] ? (64'd0 - prod_r) : prod_r;

  // constant divide correction: quotient estimate is at most one low
  assign rem    = p_r - prod_r[31:0];
  assign quot   = (rem >= {24'd0, cmd.div_c}) ? ({1'b0, q0_r} + 33'd1) : {1'b0, q0_r};
  assign t_step = (quot > {2'b0, ONE_Q30}) ? 31'd0 : (ONE_Q30 - quot[30:0]);

  assign quad    = ph_r[cmd.dim][31:30] + cmd.off;
  assign ph_frac = ph_r[cmd.dim][29:0];
  assign term_s  = $signed({{(ACC_W-33){1'b0}}, rnd_w[32:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_vld_r   <= '0;
      sig_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_amp) begin
        amp_vld_r[amp_waddr] <= 1'b1;
      end
      if (load_sig) begin
        sig_vld_r[sig_waddr] <= 1'b1;
      end
      if (cmd.out_wr) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_amp) begin
      amp_mem[amp_waddr] <= in_amplitude_value;
    end
    if (load_sig) begin
      freq_mem[sig_waddr] <= in_frequency_value;
      rate_mem[sig_waddr] <= in_rate_value;
    end
    if (cmd.rd_amp) begin
      amp_rd_r     <= amp_mem[amp_raddr];
      amp_rd_vld_r <= amp_vld_r[amp_raddr];
    end
    if (cmd.rd_sig) begin
      freq_rd_r    <= freq_mem[sig_raddr];
      rate_rd_r    <= rate_mem[sig_raddr];
      sig_rd_vld_r <= sig_vld_r[sig_raddr];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    if (cmd.take && (in_req_type == REQ_EVAL)) begin
      time0_r <= in_time_first;
      time1_r <= in_time_second;
    end
    case (cmd.wb_sel)
      WB_Z: begin
        big_r <= (prod_r[63:32] >= EXP_LIMIT);
        n_r   <= prod_r[36:32];
        f_r   <= prod_r[31:2];
        t_r   <= ONE_Q30;
      end
      WB_PH:  ph_r[cmd.dim] <= ph_raw[39:8];
      WB_P:   p_r   <= rnd_w[31:0];
      WB_Q0:  q0_r  <= prod_r[63:32];
      WB_T:   t_r   <= t_step;
      WB_E:   t_r   <= rnd_w[30:0];
      WB_R:   r_r   <= rnd_w[30:0];
      WB_X:   x_r   <= rnd_w[30:0];
      WB_X2: begin
        x2_r <= rnd_w[31:0];
        t_r  <= ONE_Q30;
      end
      WB_MAG: mag_r <= rnd_w[30:0];
      WB_ACC: acc_r <= neg_r ? (acc_r - term_s) : (acc_r + term_s);
      default: ;
    endcase
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end
    if (cmd.r_init) begin
      r_r <= ONE_Q30;
    end
    if (cmd.t_zero) begin
      t_r <= 31'd0;
    end
    if (cmd.mag_init) begin
      mag_r <= r_r;
      neg_r <= amp_eff[31];
      am_r  <= amp_mag;
    end
    if (cmd.cos_prep) begin
      rq_r  <= quad[0] ? (ONE_Q30 - {1'b0, ph_frac}) : {1'b0, ph_frac};
      neg_r <= neg_r ^ ((quad == 2'd1) || (quad == 2'd2));
    end
    if (cmd.out_wr) begin
      out_bad_r <= cmd.out_bad;
      if (cmd.out_bad) begin
        out_value_r <= '0;
      end else if (acc_r > SAT_HI) begin
        out_value_r <= SAT_HI[OUT_W-1:0];
      end else if (acc_r < SAT_LO) begin
        out_value_r <= SAT_LO[OUT_W-1:0];
      end else begin
        out_value_r <= acc_r[OUT_W-1:0];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_signal_value = out_value_r;
  assign out_bad_phase    = out_bad_r;

  assign sts.exp_n    = n_r;
  assign sts.exp_big  = big_r;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

>>> rtl/dcse_ctrl.sv
// ---------------------------------------------------------------------------
// dcse_ctrl
// Controller: configuration registers, request intake and the sequencer
// that drives the datapath through exp, cosine and accumulate steps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "damped_cosine_sum_evaluator_top_assert.svh"

module dcse_ctrl #(
  parameter int MAX_SIGNALS = 16,
  parameter int MAX_DIMS    = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dcse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dcse_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_req_type,
  input  logic [1:0]                          in_phase_index,
  output dcse_pkg::dcse_cmd_t                 cmd,
  input  dcse_pkg::dcse_sts_t                 sts
);
  import dcse_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SIG, ST_RDS, ST_MZ, ST_WZ, ST_WPH, ST_HA, ST_HB, ST_HP, ST_HC,
    ST_HD, ST_EM, ST_EW, ST_RUPD, ST_RW, ST_TERM, ST_TM, ST_COS0, ST_CX, ST_CXW,
    ST_CXX, ST_CX2W, ST_MAGM, ST_MAGW, ST_ACM, ST_ACW, ST_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            dims_r;
  logic [4:0]            sigs_r;
  logic [SIG_IDX_W-1:0]  j_r, j_nxt;
  logic [SIG_IDX_W:0]    m_r, m_nxt;
  logic [1:0]            l_r, l_nxt, k_r, k_nxt;
  logic                  d_r, d_nxt, two_d_r, two_d_nxt;
  logic                  cos_r, cos_nxt, bad_r, bad_nxt;
  logic [3:0]            i_r, i_nxt;
  logic [4:0]            ncnt_r, ncnt_nxt;
  logic                  two_d_in, bad_in, eval_in;
  logic [SIG_IDX_W:0]    m_in;
  logic [1:0]            last_l;

  assign two_d_in = (dims_r >= 2'd2) && (MAX_DIMS >= 2);
  assign m_in     = (int'(sigs_r) > MAX_SIGNALS) ? (SIG_IDX_W+1)'(MAX_SIGNALS)
                                                 : (SIG_IDX_W+1)'(sigs_r);
  assign bad_in   = !two_d_in && in_phase_index[1];
  assign eval_in  = in_valid && (in_req_type == REQ_EVAL);
  assign last_l   = two_d_r ? 2'd3 : 2'd1;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    m_nxt     = m_r;
    l_nxt     = l_r;
    k_nxt     = k_r;
    d_nxt     = d_r;
    two_d_nxt = two_d_r;
    cos_nxt   = cos_r;
    bad_nxt   = bad_r;
    i_nxt     = i_r;
    ncnt_nxt  = ncnt_r;

    cmd       = '0;
    cmd.sig   = j_r;
    cmd.term  = l_r;
    cmd.dim   = d_r;
    cmd.off   = two_d_r ? MOD_TWO[{k_r, l_r, d_r}] : MOD_ONE[{k_r[0], l_r[0]}];
    cmd.div_c = div_const(cos_r, i_r);
    cmd.div_m = div_recip(cos_r, i_r);

    unique case (state_r)
      ST_IDLE: begin
        cmd.take = in_valid;
        if (eval_in) begin
          cmd.acc_clr = 1'b1;
          two_d_nxt   = two_d_in;
          m_nxt       = m_in;
          k_nxt       = in_phase_index;
          bad_nxt     = bad_in;
          j_nxt       = '0;
          state_nxt   = (bad_in || (m_in == '0)) ? ST_OUT : ST_SIG;
        end
      end
      ST_SIG: begin
        cmd.r_init = 1'b1;
        d_nxt      = 1'b0;
        state_nxt  = ST_RDS;
      end
      ST_RDS: begin
        cmd.rd_sig = 1'b1;
        state_nxt  = ST_MZ;
      end
      ST_MZ: begin
        cmd.mul_sel = MS_ZT;
        state_nxt   = ST_WZ;
      end
      ST_WZ: begin
        cmd.wb_sel  = WB_Z;
        cmd.mul_sel = MS_PH;
        state_nxt   = ST_WPH;
      end
      ST_WPH: begin
        cmd.wb_sel = WB_PH;
        ncnt_nxt   = sts.exp_n;
        if (sts.exp_big) begin
          cmd.t_zero = 1'b1;
          state_nxt  = ST_RUPD;
        end else begin
          cos_nxt   = 1'b0;
          i_nxt     = EXP_STEPS;
          state_nxt = ST_HA;
        end
      end
      ST_HA: begin
        cmd.mul_sel = cos_r ? MS_XT : MS_FT;
        state_nxt   = ST_HB;
      end
      ST_HB: begin
        cmd.wb_sel = WB_P;
        state_nxt  = ST_HP;
      end
      ST_HP: begin
        cmd.mul_sel = MS_DIV;
        state_nxt   = ST_HC;
      end
      ST_HC: begin
        cmd.wb_sel  = WB_Q0;
        cmd.mul_sel = MS_QC;
        state_nxt   = ST_HD;
      end
      ST_HD: begin
        cmd.wb_sel = WB_T;
        if (i_r == 4'd1) begin
          if (cos_r) begin
            state_nxt = ST_MAGM;
          end else begin
            state_nxt = (ncnt_r == 5'd0) ? ST_RUPD : ST_EM;
          end
        end else begin
          i_nxt     = i_r - 4'd1;
          state_nxt = ST_HA;
        end
      end
      ST_EM: begin
        cmd.mul_sel = MS_INVE;
        state_nxt   = ST_EW;
      end
      ST_EW: begin
        cmd.wb_sel = WB_E;
        ncnt_nxt   = ncnt_r - 5'd1;
        state_nxt  = (ncnt_r == 5'd1) ? ST_RUPD : ST_EM;
      end
      ST_RUPD: begin
        cmd.mul_sel = MS_RE;
        state_nxt   = ST_RW;
      end
      ST_RW: begin
        cmd.wb_sel = WB_R;
        if (two_d_r && !d_r) begin
          d_nxt     = 1'b1;
          state_nxt = ST_RDS;
        end else begin
          d_nxt     = 1'b0;
          l_nxt     = 2'd0;
          state_nxt = ST_TERM;
        end
      end
      ST_TERM: begin
        cmd.rd_amp = 1'b1;
        state_nxt  = ST_TM;
      end
      ST_TM: begin
        cmd.mag_init = 1'b1;
        d_nxt        = 1'b0;
        state_nxt    = ST_COS0;
      end
      ST_COS0: begin
        cmd.cos_prep = 1'b1;
        state_nxt    = ST_CX;
      end
      ST_CX: begin
        cmd.mul_sel = MS_X;
        state_nxt   = ST_CXW;
      end
      ST_CXW: begin
        cmd.wb_sel = WB_X;
        state_nxt  = ST_CXX;
      end
      ST_CXX: begin
        cmd.mul_sel = MS_XX;
        state_nxt   = ST_CX2W;
      end
      ST_CX2W: begin
        cmd.wb_sel = WB_X2;
        cos_nxt    = 1'b1;
        i_nxt      = COS_STEPS;
        state_nxt  = ST_HA;
      end
      ST_MAGM: begin
        cmd.mul_sel = MS_MC;
        state_nxt   = ST_MAGW;
      end
      ST_MAGW: begin
        cmd.wb_sel = WB_MAG;
        if (two_d_r && !d_r) begin
          d_nxt     = 1'b1;
          state_nxt = ST_COS0;
        end else begin
          state_nxt = ST_ACM;
        end
      end
      ST_ACM: begin
        cmd.mul_sel = MS_AM;
        state_nxt   = ST_ACW;
      end
      ST_ACW: begin
        cmd.wb_sel = WB_ACC;
        if (l_r == last_l) begin
          if (({1'b0, j_r} + 1'b1) == m_r) begin
            state_nxt = ST_OUT;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_SIG;
          end
        end else begin
          l_nxt     = l_r + 2'd1;
          state_nxt = ST_TERM;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_wr  = 1'b1;
          cmd.out_bad = bad_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dims_r  <= 2'd1;
      sigs_r  <= 5'd1;
      j_r     <= '0;
      m_r     <= '0;
      l_r     <= '0;
      k_r     <= '0;
      d_r     <= 1'b0;
      two_d_r <= 1'b0;
      cos_r   <= 1'b0;
      bad_r   <= 1'b0;
      i_r     <= '0;
      ncnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      m_r     <= m_nxt;
      l_r     <= l_nxt;
      k_r     <= k_nxt;
      d_r     <= d_nxt;
      two_d_r <= two_d_nxt;
      cos_r   <= cos_nxt;
      bad_r   <= bad_nxt;
      i_r     <= i_nxt;
      ncnt_r  <= ncnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DIMENSIONS: dims_r <= cfg_wdata[1:0];
          REG_SIGNALS:    sigs_r <= cfg_wdata;
          default:        ;
        endcase
      end
    end
  end

  `DCSE_ASSERT_NEXT(a_bad_phase_direct, (state_r == ST_IDLE) && eval_in && bad_in, (state_r == ST_OUT) && bad_r, "bad phase request did not go straight to output")
  `DCSE_ASSERT_IMPL(a_out_slot_free, cmd.out_wr, sts.out_free, "result written while output register busy")
  `DCSE_ASSERT_IMPL(a_signal_in_range, (state_r != ST_IDLE) && (state_r != ST_OUT), {1'b0, j_r} < m_r, "signal counter beyond signals in use")
  `DCSE_ASSERT_IMPL(a_step_nonzero, (state_r == ST_HA) || (state_r == ST_HD), i_r != 4'd0, "series step counter at zero")

endmodule
